@@ rtl/m16rgb_pkg.sv @@
// Shared types, constants and helper functions for the 16-bit masked pixel to RGB888 unpacker.
// Used by every module of the block; it has no dependencies of its own.
`default_nettype none

package m16rgb_pkg;

  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned COMP_W     = 8;
  localparam int unsigned START_W    = 4;
  localparam int unsigned RUN_W      = 5;
  localparam int unsigned PROD_W     = 24;   // 255 * 16-bit value
  localparam int unsigned RECIP_W    = 25;   // floor(2^24 / d), d = 1 needs 25 bits
  localparam int unsigned RECIP_SH   = 24;
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned PIPE_DEPTH = 5;

  localparam logic [RUN_W-1:0] MAX_RUN = 5'd8;

  localparam logic [PIX_W-1:0] RED_MASK_RST   = 16'hF800;
  localparam logic [PIX_W-1:0] GREEN_MASK_RST = 16'h07E0;
  localparam logic [PIX_W-1:0] BLUE_MASK_RST  = 16'h001F;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [RUN_W-1:0]   len;
  } mask_info_t;

  // Lowest set bit and length of the run of ones that starts there.
  function automatic mask_info_t mask_decode(input logic [PIX_W-1:0] m);
    logic [PIX_W-1:0]   low_bit;
    logic [PIX_W-1:0]   fill;
    logic [PIX_W-1:0]   end_bit;
    logic [START_W-1:0] s;
    logic [RUN_W-1:0]   e;
    mask_info_t         info;
    low_bit = m & (~m + 16'd1);
    fill    = m | (m - 16'd1);
    end_bit = ~fill & (fill + 16'd1);
    s = '0;
    e = '0;
    for (int i = 0; i < PIX_W; i++) begin
      if (low_bit[i]) s = s | START_W'(i);
      if (end_bit[i]) e = e | RUN_W'(i);
    end
    // When the run reaches the top bit there is no zero above it.
    if (end_bit == '0) e = RUN_W'(PIX_W);
    info.start = s;
    info.len   = (m == '0) ? '0 : (e - {1'b0, s});
    return info;
  endfunction

  // Divisor 2^len - 1 for runs up to eight bits, with 1 for a run of length 0 or longer than eight.
  function automatic logic [DIV_W-1:0] run_divisor(input logic [RUN_W-1:0] len);
    logic [DIV_W-1:0] d;
    case (len)
      5'd2:    d = 8'd3;
      5'd3:    d = 8'd7;
      5'd4:    d = 8'd15;
      5'd5:    d = 8'd31;
      5'd6:    d = 8'd63;
      5'd7:    d = 8'd127;
      5'd8:    d = 8'd255;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^24 / d) for the divisor of the same run length.
  function automatic logic [RECIP_W-1:0] run_recip(input logic [RUN_W-1:0] len);
    logic [RECIP_W-1:0] r;
    case (len)
      5'd2:    r = 25'd5592405;
      5'd3:    r = 25'd2396745;
      5'd4:    r = 25'd1118481;
      5'd5:    r = 25'd541200;
      5'd6:    r = 25'd266305;
      5'd7:    r = 25'd132104;
      5'd8:    r = 25'd65793;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/m16rgb_cfg.sv @@
// Mask registers of the unpacker together with their decoded start and run length.
// Depends on m16rgb_pkg.
`default_nettype none

module m16rgb_cfg
  import m16rgb_pkg::*;
(
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_idx_i,
  input  wire logic [PIX_W-1:0]                  cfg_data_i,
  output logic      [NUM_CHAN-1:0][PIX_W-1:0]    mask_o,
  output mask_info_t [NUM_CHAN-1:0]              info_o
);

  logic       [NUM_CHAN-1:0][PIX_W-1:0] mask_q;
  mask_info_t [NUM_CHAN-1:0]            info_q;
  mask_info_t                           info_d;

  // Decoding at write time keeps the search off the pixel path.
  assign info_d = mask_decode(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q[REG_RED]   <= RED_MASK_RST;
      mask_q[REG_GREEN] <= GREEN_MASK_RST;
      mask_q[REG_BLUE]  <= BLUE_MASK_RST;
      info_q[REG_RED]   <= mask_decode(RED_MASK_RST);
      info_q[REG_GREEN] <= mask_decode(GREEN_MASK_RST);
      info_q[REG_BLUE]  <= mask_decode(BLUE_MASK_RST);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RED: begin
          mask_q[REG_RED] <= cfg_data_i;
          info_q[REG_RED] <= info_d;
        end
        REG_GREEN: begin
          mask_q[REG_GREEN] <= cfg_data_i;
          info_q[REG_GREEN] <= info_d;
        end
        REG_BLUE: begin
          mask_q[REG_BLUE] <= cfg_data_i;
          info_q[REG_BLUE] <= info_d;
        end
        default: begin
        end
      endcase
    end
  end

  assign mask_o = mask_q;
  assign info_o = info_q;

endmodule

`default_nettype wire

@@ rtl/m16rgb_chan.sv @@
// Five-stage datapath that expands one colour channel of a pixel to eight bits.
// Depends on m16rgb_pkg; the valid bits travel in the top level.
`default_nettype none

module m16rgb_chan
  import m16rgb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [PIX_W-1:0]  pixel_i,
  input  wire logic [PIX_W-1:0]  mask_i,
  input  mask_info_t             info_i,
  output logic      [COMP_W-1:0] comp_o,
  output logic                   too_long_o
);

  // Stage 1: masked field aligned to bit 0.
  logic [PIX_W-1:0]   val_q;
  logic [RUN_W-1:0]   len1_q;
  // Stage 2: 255 * value, divisor selection.
  logic [PROD_W-1:0]  prod_q;
  logic [RECIP_W-1:0] recip_q;
  logic [DIV_W-1:0]   div2_q;
  logic               long2_q;
  // Stage 3: quotient estimate, at most one below the true quotient.
  logic [PROD_W+RECIP_W-1:0] est_full;
  logic [PROD_W-1:0]  est3_q;
  logic [PROD_W-1:0]  prod3_q;
  logic [DIV_W-1:0]   div3_q;
  logic               long3_q;
  // Stage 4: estimate times divisor.
  logic [PROD_W+DIV_W-1:0] back_q;
  logic [PROD_W-1:0]  prod4_q;
  logic [COMP_W-1:0]  est4_q;
  logic [DIV_W-1:0]   div4_q;
  logic               long4_q;
  // Stage 5: corrected result.
  logic [PROD_W+DIV_W-1:0] rem;
  logic               bump;
  logic [COMP_W-1:0]  comp_q;
  logic               long5_q;

  assign est_full = prod_q * recip_q;
  assign rem      = {{DIV_W{1'b0}}, prod4_q} - back_q;
  assign bump     = rem >= {{PROD_W{1'b0}}, div4_q};

  always_ff @(posedge clk_i) begin
    val_q  <= (pixel_i & mask_i) >> info_i.start;
    len1_q <= info_i.len;

    prod_q  <= {val_q, {COMP_W{1'b0}}} - {{COMP_W{1'b0}}, val_q};
    recip_q <= run_recip(len1_q);
    div2_q  <= run_divisor(len1_q);
    long2_q <= len1_q > MAX_RUN;

    est3_q  <= est_full[RECIP_SH +: PROD_W];
    prod3_q <= prod_q;
    div3_q  <= div2_q;
    long3_q <= long2_q;

    back_q  <= est3_q * div3_q;
    prod4_q <= prod3_q;
    est4_q  <= est3_q[COMP_W-1:0];
    div4_q  <= div3_q;
    long4_q <= long3_q;

    // A run too long for the table yields zero for this channel.
    comp_q  <= long4_q ? '0 : (est4_q + COMP_W'(bump));
    long5_q <= long4_q;
  end

  assign comp_o     = comp_q;
  assign too_long_o = long5_q;

endmodule

`default_nettype wire

@@ rtl/masked_16bit_pixel_to_rgb888.sv @@
// Top level of the masked 16-bit pixel to RGB888 unpacker.
// Depends on m16rgb_pkg, m16rgb_cfg and m16rgb_chan.
//
// Usage:
//   A pixel is taken at a rising edge with start high; busy is always low, so
//   a new pixel may be offered in every cycle.
//   Results leave the last register stage: done_o is high for exactly one
//   cycle while red_o, green_o, blue_o and field_too_long_o hold the item.
//   Each channel has five register stages: align the masked field, form 255
//   times the value, multiply by a reciprocal of the divisor, multiply back,
//   and correct the quotient by at most one.
//   Throughput is one item per clock cycle.
//   The receiver has no way to hold results off; they must be taken when shown.
//   Mask registers are written through cfg_we_i, cfg_idx_i (0 red, 1 green,
//   2 blue; 3 is ignored) and cfg_data_i; the user must write them only while
//   no items are in flight, as the block does not enforce it. Reset clears the
//   valid pipeline and loads the RGB565 masks. A channel whose mask run is
//   longer than eight bits gives zero and raises field_too_long_o.
`default_nettype none

module masked_16bit_pixel_to_rgb888
  import m16rgb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [PIX_W-1:0]  pixel_i,
  output logic                   done_o,
  output logic      [COMP_W-1:0] red_o,
  output logic      [COMP_W-1:0] green_o,
  output logic      [COMP_W-1:0] blue_o,
  output logic                   field_too_long_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [PIX_W-1:0]  cfg_data_i
);

  logic       [NUM_CHAN-1:0][PIX_W-1:0]  mask;
  mask_info_t [NUM_CHAN-1:0]             info;
  logic       [NUM_CHAN-1:0][COMP_W-1:0] comp;
  logic       [NUM_CHAN-1:0]             too_long;
  logic       [PIPE_DEPTH-1:0]           vld_q;
  logic       [PIPE_DEPTH-1:0]           vld_d;

  m16rgb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mask_o     (mask),
    .info_o     (info)
  );

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    m16rgb_chan u_chan (
      .clk_i      (clk_i),
      .pixel_i    (pixel_i),
      .mask_i     (mask[c]),
      .info_i     (info[c]),
      .comp_o     (comp[c]),
      .too_long_o (too_long[c])
    );
  end

  assign busy  = 1'b0;
  assign vld_d = {vld_q[PIPE_DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o           = vld_q[PIPE_DEPTH-1];
  assign red_o            = comp[REG_RED];
  assign green_o          = comp[REG_GREEN];
  assign blue_o           = comp[REG_BLUE];
  assign field_too_long_o = |too_long;

endmodule

`default_nettype wire

@@ tb/sv/tb_masked_16bit_pixel_to_rgb888.sv @@
// Self-checking testbench for the masked 16-bit pixel to RGB888 unpacker.
// Drives pixels and mask writes, checks each RGB item on done_o, typed in or predicted.
// Depends on m16rgb_pkg and the masked_16bit_pixel_to_rgb888 RTL.
`default_nettype none

module tb_masked_16bit_pixel_to_rgb888;
  import m16rgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CFG_IDX_SPARE  = 2'd3;
  localparam int unsigned RANDOM_ITEMS   = 600;
  localparam int unsigned MAX_GAP        = 13;
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned N_CASES        = 21;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              too_long;
  } rgb_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_mask;
    logic [PIX_W-1:0] green_mask;
    logic [PIX_W-1:0] blue_mask;
    logic [PIX_W-1:0] pixel;
    logic             known;
    rgb_item_t        rgb;
  } pixel_case_t;

  localparam rgb_item_t NO_RGB = '0;

  // Rows marked known carry the result typed in; the rest go to the predictor.
  pixel_case_t pixel_cases [N_CASES] = '{
    '{16'hF800, 16'h07E0, 16'h001F, 16'h0000, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
    '{16'hF800, 16'h07E0, 16'h001F, 16'hFFFF, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{16'hF800, 16'h07E0, 16'h001F, 16'hF800, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
    '{16'hF800, 16'h07E0, 16'h001F, 16'h07E0, 1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
    '{16'hF800, 16'h07E0, 16'h001F, 16'h001F, 1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
    '{16'hF800, 16'h07E0, 16'h001F, 16'h8410, 1'b0, NO_RGB},
    '{16'hF800, 16'h07E0, 16'h001F, 16'h5555, 1'b0, NO_RGB},
    '{16'hF800, 16'h07E0, 16'h001F, 16'hAAAA, 1'b0, NO_RGB},
    '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
    '{16'h0000, 16'h0000, 16'h0000, 16'h1234, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
    '{16'hFFFF, 16'h00FF, 16'hFF00, 16'hFFFF, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b1}},
    '{16'hFFFF, 16'h00FF, 16'hFF00, 16'h1234, 1'b0, NO_RGB},
    '{16'h01FF, 16'h0001, 16'h8000, 16'hFFFF, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b1}},
    '{16'h01FF, 16'h0001, 16'h8000, 16'h7FFE, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{16'h01FF, 16'h0001, 16'h8000, 16'h8001, 1'b0, NO_RGB},
    '{16'h0F0F, 16'h00F5, 16'h8001, 16'hFFFF, 1'b0, NO_RGB},
    '{16'h0F0F, 16'h00F5, 16'h8001, 16'hA5A5, 1'b0, NO_RGB},
    '{16'hFF00, 16'h0FF0, 16'h00FF, 16'hFFFF, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{16'hFF00, 16'h0FF0, 16'h00FF, 16'h0180, 1'b0, NO_RGB},
    '{16'hFF00, 16'h0FF0, 16'h00FF, 16'h0000, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
    '{16'hFF00, 16'h0FF0, 16'h00FF, 16'h7E81, 1'b0, NO_RGB}
  };

  logic              clk_i;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  logic [PIX_W-1:0]  pixel_i    = '0;
  logic              done_o;
  logic [COMP_W-1:0] red_o;
  logic [COMP_W-1:0] green_o;
  logic [COMP_W-1:0] blue_o;
  logic              field_too_long_o;
  logic              cfg_we_i   = 1'b0;
  logic [1:0]        cfg_idx_i  = REG_RED;
  logic [PIX_W-1:0]  cfg_data_i = '0;

  // Mask copies used for prediction, updated from the write port itself.
  logic [PIX_W-1:0] red_mask_q   = RED_MASK_RST;
  logic [PIX_W-1:0] green_mask_q = GREEN_MASK_RST;
  logic [PIX_W-1:0] blue_mask_q  = BLUE_MASK_RST;

  // Typed-in result for the item on offer, handed to the monitor at acceptance.
  logic      pend_known = 1'b0;
  rgb_item_t pend_rgb   = '0;

  rgb_item_t   rgb_q [$];
  int unsigned pixels_in     = 0;
  int unsigned pixels_out    = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned mask_settings = 0;

  masked_16bit_pixel_to_rgb888 uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .pixel_i          (pixel_i),
    .done_o           (done_o),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o),
    .field_too_long_o (field_too_long_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Returns {too_long, component} for one channel.
  function automatic logic [COMP_W:0] expand_component(input logic [PIX_W-1:0] pix,
                                                        input logic [PIX_W-1:0] mask);
    logic [PIX_W-1:0] m;
    int unsigned      lsb;
    int unsigned      run;
    int unsigned      divisor;
    int unsigned      field;
    m   = mask;
    lsb = 0;
    run = 0;
    if (mask == '0) return '0;
    while (!m[0]) begin
      m = m >> 1;
      lsb++;
    end
    while (m[0]) begin
      m = m >> 1;
      run++;
    end
    if (run > 8) return {1'b1, 8'd0};
    divisor = (run < 2) ? 1 : (1 << run) - 1;
    field   = 32'(pix & mask) >> lsb;
    return {1'b0, COMP_W'((255 * field) / divisor)};
  endfunction

  function automatic rgb_item_t predict_rgb(input logic [PIX_W-1:0] pix);
    logic [COMP_W:0] r;
    logic [COMP_W:0] g;
    logic [COMP_W:0] b;
    rgb_item_t       item;
    r = expand_component(pix, red_mask_q);
    g = expand_component(pix, green_mask_q);
    b = expand_component(pix, blue_mask_q);
    item.red      = r[COMP_W-1:0];
    item.green    = g[COMP_W-1:0];
    item.blue     = b[COMP_W-1:0];
    item.too_long = r[COMP_W] | g[COMP_W] | b[COMP_W];
    return item;
  endfunction

  // Contiguous runs dominate; zero, full, over-long and scattered masks are mixed in.
  function automatic logic [PIX_W-1:0] random_mask();
    int unsigned kind;
    int unsigned run;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return '0;
      1: return '1;
      2: return PIX_W'($urandom);
      3: run = $urandom_range(9, 16);
      default: run = $urandom_range(1, 8);
    endcase
    return PIX_W'(((32'd1 << run) - 1) << $urandom_range(0, PIX_W - run));
  endfunction

  task automatic report_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: item %0d %s mismatch: expected %0d, got %0d",
               $realtime, pixels_out, name, exp_val, act_val);
  endtask

  // Monitor: records accepted pixels, checks results and follows mask writes.
  always @(posedge clk_i) begin : monitor
    rgb_item_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        pixels_in++;
        rgb_q.push_back(pend_known ? pend_rgb : predict_rgb(pixel_i));
      end
      if (done_o) begin
        pixels_out++;
        if (rgb_q.size() == 0) begin
          report_field("unexpected result", 0, 1);
        end else begin
          want = rgb_q.pop_front();
          if (red_o !== want.red) report_field("red", want.red, red_o);
          if (green_o !== want.green) report_field("green", want.green, green_o);
          if (blue_o !== want.blue) report_field("blue", want.blue, blue_o);
          if (field_too_long_o !== want.too_long)
            report_field("field_too_long", want.too_long, field_too_long_o);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RED:   red_mask_q   = cfg_data_i;
          REG_GREEN: green_mask_q = cfg_data_i;
          REG_BLUE:  blue_mask_q  = cfg_data_i;
          default:   ;
        endcase
      end
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d items outstanding", rgb_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offers one pixel after a gap and returns at the edge that accepts it.
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input int unsigned gap,
                            input logic known, input rgb_item_t rgb);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    pixel_i    <= pix;
    pend_known <= known;
    pend_rgb   <= rgb;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops offering and waits until every outstanding item has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (rgb_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Writes all three masks on consecutive edges, optionally hitting the unused index too.
  task automatic write_masks(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input bit spare);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RED;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_idx_i  <= REG_GREEN;
    cfg_data_i <= g;
    @(posedge clk_i);
    cfg_idx_i  <= REG_BLUE;
    cfg_data_i <= b;
    @(posedge clk_i);
    if (spare) begin
      cfg_idx_i  <= CFG_IDX_SPARE;
      cfg_data_i <= PIX_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    mask_settings++;
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] cur_r;
    logic [PIX_W-1:0] cur_g;
    logic [PIX_W-1:0] cur_b;
    logic [PIX_W-1:0] pix;
    int unsigned      random_sent;
    int unsigned      phase;
    int unsigned      n_items;
    bit               no_idle;
    cur_r       = RED_MASK_RST;
    cur_g       = GREEN_MASK_RST;
    cur_b       = BLUE_MASK_RST;
    random_sent = 0;
    phase       = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pixel_cases[i]) begin
      if (pixel_cases[i].red_mask != cur_r || pixel_cases[i].green_mask != cur_g ||
          pixel_cases[i].blue_mask != cur_b) begin
        drain();
        cur_r = pixel_cases[i].red_mask;
        cur_g = pixel_cases[i].green_mask;
        cur_b = pixel_cases[i].blue_mask;
        write_masks(cur_r, cur_g, cur_b, 1'b0);
      end
      push_pixel(pixel_cases[i].pixel, $urandom_range(0, MAX_GAP),
                 pixel_cases[i].known, pixel_cases[i].rgb);
    end

    // Random phases: a fresh mask setting each, some with back-to-back items.
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      write_masks(random_mask(), random_mask(), random_mask(),
                  phase == 0 || $urandom_range(0, 3) == 0);
      n_items = $urandom_range(20, 60);
      no_idle = $urandom_range(0, 3) == 0;
      for (int unsigned k = 0; k < n_items; k++) begin
        // In the first phase, and now and then later, let the pipeline run dry.
        if (k == n_items / 2 && (phase == 0 || $urandom_range(0, 2) == 0)) drain();
        case ($urandom_range(0, 15))
          0:       pix = '0;
          1:       pix = '1;
          default: pix = PIX_W'($urandom);
        endcase
        push_pixel(pix, no_idle ? 0 : $urandom_range(0, MAX_GAP), 1'b0, NO_RGB);
        random_sent++;
      end
      phase++;
    end

    drain();
    repeat (PIPE_DEPTH + 2) @(negedge clk_i);
    if (rgb_q.size() != 0) begin
      $display("%0d expected items never arrived", rgb_q.size());
      mismatches += rgb_q.size();
    end
    $display("Converted %0d pixels (%0d returned) over %0d mask settings,",
             pixels_in, pixels_out, mask_settings);
    $display("including zero, full, over-long and scattered masks; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
